[rtl/core/ntc_pkg.sv]
// ntc_pkg: shared constants, status codes, register indices and calibration table
// no dependencies
package ntc_pkg;

	localparam int TableDepth = 141;
	localparam int ZeroIndex  = 10;
	localparam int AdcW       = 16;
	localparam int RomW       = 12;
	localparam int TempW      = 12;
	localparam int StatW      = 3;
	localparam int CfgIdxW    = 1;
	localparam logic [AdcW-1:0] ShortReset = 16'd15;
	localparam logic [AdcW-1:0] OpenReset  = 16'd4096;

	typedef enum logic [StatW-1:0] {
		ST_OK    = 3'd0,
		ST_SHORT = 3'd1,
		ST_OPEN  = 3'd2,
		ST_BELOW = 3'd3,
		ST_ABOVE = 3'd4
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SHORT = 1'b0,
		REG_OPEN  = 1'b1
	} cfg_reg_t;

	// calibration table, ascending converter codes, one entry per degree
	function automatic logic [RomW-1:0] cal_rom(input logic [7:0] idx);
		logic [RomW-1:0] r;
		case (idx)
			8'd0: r = 12'd180; 8'd1: r = 12'd189; 8'd2: r = 12'd200; 8'd3: r = 12'd210;
			8'd4: r = 12'd221; 8'd5: r = 12'd233; 8'd6: r = 12'd245; 8'd7: r = 12'd258;
			8'd8: r = 12'd271; 8'd9: r = 12'd284; 8'd10: r = 12'd298; 8'd11: r = 12'd313;
			8'd12: r = 12'd328; 8'd13: r = 12'd344; 8'd14: r = 12'd361; 8'd15: r = 12'd372;
			8'd16: r = 12'd396; 8'd17: r = 12'd416; 8'd18: r = 12'd440; 8'd19: r = 12'd462;
			8'd20: r = 12'd482; 8'd21: r = 12'd508; 8'd22: r = 12'd528; 8'd23: r = 12'd558;
			8'd24: r = 12'd576; 8'd25: r = 12'd600; 8'd26: r = 12'd632; 8'd27: r = 12'd654;
			8'd28: r = 12'd682; 8'd29: r = 12'd710; 8'd30: r = 12'd734; 8'd31: r = 12'd758;
			8'd32: r = 12'd794; 8'd33: r = 12'd826; 8'd34: r = 12'd860; 8'd35: r = 12'd892;
			8'd36: r = 12'd917; 8'd37: r = 12'd950; 8'd38: r = 12'd982; 8'd39: r = 12'd1014;
			8'd40: r = 12'd1044; 8'd41: r = 12'd1075; 8'd42: r = 12'd1107; 8'd43: r = 12'd1146;
			8'd44: r = 12'd1182; 8'd45: r = 12'd1260; 8'd46: r = 12'd1294; 8'd47: r = 12'd1324;
			8'd48: r = 12'd1372; 8'd49: r = 12'd1393; 8'd50: r = 12'd1415; 8'd51: r = 12'd1465;
			8'd52: r = 12'd1497; 8'd53: r = 12'd1556; 8'd54: r = 12'd1598; 8'd55: r = 12'd1621;
			8'd56: r = 12'd1652; 8'd57: r = 12'd1720; 8'd58: r = 12'd1740; 8'd59: r = 12'd1760;
			8'd60: r = 12'd1804; 8'd61: r = 12'd1842; 8'd62: r = 12'd1882; 8'd63: r = 12'd1920;
			8'd64: r = 12'd1958; 8'd65: r = 12'd1994; 8'd66: r = 12'd2045; 8'd67: r = 12'd2083;
			8'd68: r = 12'd2122; 8'd69: r = 12'd2142; 8'd70: r = 12'd2193; 8'd71: r = 12'd2245;
			8'd72: r = 12'd2290; 8'd73: r = 12'd2330; 8'd74: r = 12'd2359; 8'd75: r = 12'd2400;
			8'd76: r = 12'd2418; 8'd77: r = 12'd2460; 8'd78: r = 12'd2502; 8'd79: r = 12'd2539;
			8'd80: r = 12'd2553; 8'd81: r = 12'd2580; 8'd82: r = 12'd2614; 8'd83: r = 12'd2648;
			8'd84: r = 12'd2681; 8'd85: r = 12'd2710; 8'd86: r = 12'd2736; 8'd87: r = 12'd2765;
			8'd88: r = 12'd2788; 8'd89: r = 12'd2812; 8'd90: r = 12'd2845; 8'd91: r = 12'd2870;
			8'd92: r = 12'd2894; 8'd93: r = 12'd2934; 8'd94: r = 12'd2963; 8'd95: r = 12'd2989;
			8'd96: r = 12'd3022; 8'd97: r = 12'd3042; 8'd98: r = 12'd3064; 8'd99: r = 12'd3092;
			8'd100: r = 12'd3112; 8'd101: r = 12'd3132; 8'd102: r = 12'd3154; 8'd103: r = 12'd3176;
			8'd104: r = 12'd3192; 8'd105: r = 12'd3202; 8'd106: r = 12'd3222; 8'd107: r = 12'd3240;
			8'd108: r = 12'd3269; 8'd109: r = 12'd3292; 8'd110: r = 12'd3315; 8'd111: r = 12'd3338;
			8'd112: r = 12'd3354; 8'd113: r = 12'd3374; 8'd114: r = 12'd3384; 8'd115: r = 12'd3392;
			8'd116: r = 12'd3409; 8'd117: r = 12'd3426; 8'd118: r = 12'd3442; 8'd119: r = 12'd3458;
			8'd120: r = 12'd3473; 8'd121: r = 12'd3489; 8'd122: r = 12'd3503; 8'd123: r = 12'd3518;
			8'd124: r = 12'd3532; 8'd125: r = 12'd3545; 8'd126: r = 12'd3559; 8'd127: r = 12'd3572;
			8'd128: r = 12'd3585; 8'd129: r = 12'd3597; 8'd130: r = 12'd3609; 8'd131: r = 12'd3621;
			8'd132: r = 12'd3632; 8'd133: r = 12'd3643; 8'd134: r = 12'd3654; 8'd135: r = 12'd3665;
			8'd136: r = 12'd3675; 8'd137: r = 12'd3685; 8'd138: r = 12'd3695; 8'd139: r = 12'd3705;
			8'd140: r = 12'd3714;
			default: r = 12'd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/ntc_search_step.sv]
// ntc_search_step: one registered bisection step over the calibration table
// depends on ntc_pkg
module ntc_search_step import ntc_pkg::*; #(
	parameter int IDX_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             vld_in,
	input  logic [AdcW-1:0]  v_in,
	input  logic [IDX_W-1:0] lo_in,
	input  logic [IDX_W-1:0] hi_in,
	input  logic             act_in,
	input  logic [StatW-1:0] st_in,
	output logic             vld_out,
	output logic [AdcW-1:0]  v_out,
	output logic [IDX_W-1:0] lo_out,
	output logic [IDX_W-1:0] hi_out,
	output logic             act_out,
	output logic [StatW-1:0] st_out
);
	logic [IDX_W:0]   sum;
	logic [IDX_W-1:0] mid;
	logic             go_up;

	// narrow bracket toward the reading once it is wider than one entry
	always_comb begin
		sum   = {1'b0, lo_in} + {1'b0, hi_in};
		mid   = sum[IDX_W:1];
		go_up = (v_in <= AdcW'(cal_rom(8'(hi_in)))) && (v_in > AdcW'(cal_rom(8'(mid))));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (adv) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_out   <= v_in;
			act_out <= act_in;
			st_out  <= st_in;
			lo_out  <= lo_in;
			hi_out  <= hi_in;
			if (act_in && (hi_in - lo_in > IDX_W'(1))) begin
				if (go_up) begin
					lo_out <= mid;
				end else begin
					hi_out <= mid;
				end
			end
		end
	end
endmodule

[rtl/core/ntc_interp.sv]
// ntc_interp: interpolation pipeline, multiply stage, divider stages, result
// depends on ntc_pkg
module ntc_interp import ntc_pkg::*; #(
	parameter int IDX_W     = 8,
	parameter int ZERO_INDEX = ZeroIndex
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    vld_in,
	input  logic [AdcW-1:0]         v_in,
	input  logic [IDX_W-1:0]        lo_in,
	input  logic [IDX_W-1:0]        hi_in,
	input  logic                    act_in,
	input  logic [StatW-1:0]        st_in,
	output logic                    vld_out,
	output logic [StatW-1:0]        st_out,
	output logic signed [TempW-1:0] temp_out
);
	// dividend (d*100+5)/10 is exactly d*10, kept at 20 bits; span 12 bits
	localparam int NumW = 20;
	localparam int DenW = RomW;
	localparam int NStg = NumW / 4;

	logic [RomW-1:0] a, b;
	logic [AdcW-1:0] d;
	logic [NumW-1:0] num_c;
	logic signed [TempW-1:0] base_c;

	// bracket fetch, offset from the lower entry, scaled dividend and base temperature
	always_comb begin
		a      = cal_rom(8'(lo_in));
		b      = cal_rom(8'(hi_in));
		d      = (v_in >= AdcW'(a)) ? v_in - AdcW'(a) : '0;
		// d*10 as d*8 + d*2
		num_c  = NumW'({d[RomW-1:0], 3'b000}) + NumW'({d[RomW-1:0], 1'b0});
		base_c = TempW'((signed'({1'b0, lo_in}) - ZERO_INDEX) * 10);
	end

	logic [NStg:0]                    vv;
	logic [StatW-1:0]                 st_p  [NStg+1];
	logic signed [TempW-1:0]          base_p[NStg+1];
	logic                             div_p [NStg+1];
	logic [NumW-1:0]                  q_p   [NStg+1];
	logic [DenW:0]                    r_p   [NStg+1];
	logic [DenW-1:0]                  den_p [NStg+1];

	// stage 0 register: operands and early result
	always_ff @(posedge clk) begin
		if (adv) begin
			st_p[0]   <= st_in;
			q_p[0]    <= num_c;
			r_p[0]    <= '0;
			den_p[0]  <= b - a;
			div_p[0]  <= 1'b0;
			base_p[0] <= '0;
			if (act_in && st_in == ST_OK) begin
				if (AdcW'(a) == v_in) begin
					base_p[0] <= base_c;
				end else if (AdcW'(b) == v_in) begin
					base_p[0] <= TempW'((signed'({1'b0, hi_in}) - ZERO_INDEX) * 10);
				end else begin
					base_p[0] <= base_c;
					div_p[0]  <= (b > a);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vv <= '0;
		end else if (adv) begin
			vv <= {vv[NStg-1:0], vld_in};
		end
	end

	// restoring divider, four quotient bits per stage
	for (genvar g = 0; g < NStg; g++) begin : g_div
		logic [NumW-1:0] q;
		logic [DenW:0]   r, t;
		always_comb begin
			q = q_p[g];
			r = r_p[g];
			for (int k = 0; k < 4; k++) begin
				t = {r[DenW-1:0], q[NumW-1]};
				q = {q[NumW-2:0], 1'b0};
				if (t >= {1'b0, den_p[g]}) begin
					t    = t - {1'b0, den_p[g]};
					q[0] = 1'b1;
				end
				r = t;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				q_p[g+1]    <= q;
				r_p[g+1]    <= r;
				den_p[g+1]  <= den_p[g];
				st_p[g+1]   <= st_p[g];
				base_p[g+1] <= base_p[g];
				div_p[g+1]  <= div_p[g];
			end
		end
	end

	assign vld_out  = vv[NStg];
	assign st_out   = st_p[NStg];
	assign temp_out = div_p[NStg] ? base_p[NStg] + signed'(TempW'(q_p[NStg])) : base_p[NStg];
endmodule

[rtl/core/ntc_table_temperature.sv]
// ntc_table_temperature: reading to fault status and temperature in tenths
// depends on ntc_pkg, ntc_search_step, ntc_interp
//
// channel | signals                        | direction
// in      | in_valid, in_ready, adc_value  | item from converter filter
// out     | out_valid, out_ready, status,  | item to consumer
//         | temp_tenths                    |
// cfg     | cfg_we, cfg_idx, cfg_wdata     | register writes
//
// one item enters per cycle while the output is not stalled; stages: classify, eight
// bisection steps, a multiply stage and five divider stages of four bits each
// the whole pipeline advances together; a stalled output freezes every stage
// reset clears valid bits and loads the default thresholds
module ntc_table_temperature import ntc_pkg::*; #(
	parameter int TABLE_DEPTH = TableDepth,
	parameter int ZERO_INDEX  = ZeroIndex
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [AdcW-1:0]         adc_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [StatW-1:0]        status,
	output logic signed [TempW-1:0] temp_tenths,
	input  logic                    cfg_we,
	input  logic [CfgIdxW-1:0]      cfg_idx,
	input  logic [AdcW-1:0]         cfg_wdata
);
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int NStep = IDX_W;

	logic [AdcW-1:0] short_q, open_q;
	logic            adv;

	// thresholds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q <= ShortReset;
			open_q  <= OpenReset;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_SHORT: short_q <= cfg_wdata;
				REG_OPEN:  open_q  <= cfg_wdata;
				default:   ;
			endcase
		end
	end

	assign adv      = out_ready || !out_valid;
	assign in_ready = adv;

	// fault classification
	logic            vld_s1, act_s1;
	logic [AdcW-1:0] v_s1;
	logic [StatW-1:0] st_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1   <= adc_value;
			act_s1 <= 1'b0;
			if (adc_value <= short_q) begin
				st_s1 <= ST_SHORT;
			end else if (adc_value >= open_q) begin
				st_s1 <= ST_OPEN;
			end else if (adc_value < AdcW'(cal_rom(8'd0))) begin
				st_s1 <= ST_BELOW;
			end else if (adc_value > AdcW'(cal_rom(8'(TABLE_DEPTH - 1)))) begin
				st_s1 <= ST_ABOVE;
			end else begin
				st_s1  <= ST_OK;
				act_s1 <= 1'b1;
			end
		end
	end

	logic             sv [NStep+1];
	logic [AdcW-1:0]  sval[NStep+1];
	logic [IDX_W-1:0] slo[NStep+1], shi[NStep+1];
	logic             sact[NStep+1];
	logic [StatW-1:0] sst[NStep+1];

	assign sv[0]   = vld_s1;
	assign sval[0] = v_s1;
	assign slo[0]  = '0;
	assign shi[0]  = IDX_W'(TABLE_DEPTH - 1);
	assign sact[0] = act_s1;
	assign sst[0]  = st_s1;

	// bisection chain
	for (genvar g = 0; g < NStep; g++) begin : g_step
		ntc_search_step #(.IDX_W(IDX_W)) u_step (
			.clk, .arst_n, .adv,
			.vld_in(sv[g]), .v_in(sval[g]), .lo_in(slo[g]), .hi_in(shi[g]),
			.act_in(sact[g]), .st_in(sst[g]),
			.vld_out(sv[g+1]), .v_out(sval[g+1]), .lo_out(slo[g+1]),
			.hi_out(shi[g+1]), .act_out(sact[g+1]), .st_out(sst[g+1])
		);
	end

	ntc_interp #(.IDX_W(IDX_W), .ZERO_INDEX(ZERO_INDEX)) u_interp (
		.clk, .arst_n, .adv,
		.vld_in(sv[NStep]), .v_in(sval[NStep]), .lo_in(slo[NStep]), .hi_in(shi[NStep]),
		.act_in(sact[NStep]), .st_in(sst[NStep]),
		.vld_out(out_valid), .st_out(status), .temp_out(temp_tenths)
	);
endmodule

[rtl/core/ntc_checker.sv]
// ntc_checker: port-level checks on the temperature block
// depends on ntc_pkg, binds to ntc_table_temperature
module ntc_checker import ntc_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [StatW-1:0]        status,
	input logic signed [TempW-1:0] temp_tenths
);
	// result held while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(temp_tenths))
		else $error("result changed under stall");
	// faults carry zero temperature
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> temp_tenths == '0)
		else $error("fault with temperature");
	// range of ok temperatures
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> temp_tenths >= -100 && temp_tenths <= 1300)
		else $error("temperature out of range");
	// input ready whenever output is free
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("stalled without pending result");
endmodule

bind ntc_table_temperature ntc_checker u_chk (
	.clk, .arst_n, .in_ready, .out_valid, .out_ready, .status, .temp_tenths
);

[tb/ntc_table_temperature_tb.sv]
// ntc_table_temperature_tb: self-checking bench for the thermistor table lookup
// depends on ntc_pkg and ntc_table_temperature; predicts status and tenths per reading
module ntc_table_temperature_tb;
	import ntc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LatencyCycles = 15;
	localparam longint CycleLimit = 400000;

	typedef struct packed {
		status_t           st;
		logic signed [11:0] tenths;
	} reading_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [AdcW-1:0]         adc_value;
	logic                    out_valid;
	logic                    out_ready;
	logic [StatW-1:0]        status;
	logic signed [TempW-1:0] temp_tenths;
	logic                    cfg_we;
	logic [CfgIdxW-1:0]      cfg_idx;
	logic [AdcW-1:0]         cfg_wdata;

	// thresholds as the bench believes them to be
	logic [15:0] short_lvl;
	logic [15:0] open_lvl;
	logic [11:0] cal_table [TableDepth];

	reading_result_t pending_temps[$];
	int  mismatches;
	int  results_seen;
	int  readings_sent;
	longint cycle_count;
	bit  stall_mode;

	ntc_table_temperature DUT (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// calibration codes, entered by hand
	initial begin
		int vals [TableDepth] = '{
			180, 189, 200, 210, 221, 233, 245, 258, 271, 284,
			298, 313, 328, 344, 361, 372, 396, 416, 440, 462,
			482, 508, 528, 558, 576, 600, 632, 654, 682, 710,
			734, 758, 794, 826, 860, 892, 917, 950, 982, 1014,
			1044, 1075, 1107, 1146, 1182, 1260, 1294, 1324, 1372, 1393,
			1415, 1465, 1497, 1556, 1598, 1621, 1652, 1720, 1740, 1760,
			1804, 1842, 1882, 1920, 1958, 1994, 2045, 2083, 2122, 2142,
			2193, 2245, 2290, 2330, 2359, 2400, 2418, 2460, 2502, 2539,
			2553, 2580, 2614, 2648, 2681, 2710, 2736, 2765, 2788, 2812,
			2845, 2870, 2894, 2934, 2963, 2989, 3022, 3042, 3064, 3092,
			3112, 3132, 3154, 3176, 3192, 3202, 3222, 3240, 3269, 3292,
			3315, 3338, 3354, 3374, 3384, 3392, 3409, 3426, 3442, 3458,
			3473, 3489, 3503, 3518, 3532, 3545, 3559, 3572, 3585, 3597,
			3609, 3621, 3632, 3643, 3654, 3665, 3675, 3685, 3695, 3705,
			3714};
		for (int i = 0; i < TableDepth; i++) cal_table[i] = 12'(vals[i]);
	end

	// expected status and temperature for one reading
	function automatic reading_result_t predict_temp(logic [15:0] v);
		reading_result_t r;
		int lo, hi, mid, a, b, d;
		r.st = ST_OK;
		r.tenths = '0;
		if (v <= short_lvl) r.st = ST_SHORT;
		else if (v >= open_lvl) r.st = ST_OPEN;
		else if (v < cal_table[0]) r.st = ST_BELOW;
		else if (v > cal_table[TableDepth-1]) r.st = ST_ABOVE;
		else begin
			lo = 0;
			hi = TableDepth - 1;
			while (hi - lo > 1) begin
				mid = (lo + hi) / 2;
				if (v <= cal_table[hi] && v > cal_table[mid]) lo = mid;
				else hi = mid;
			end
			a = int'(cal_table[lo]);
			b = int'(cal_table[hi]);
			if (a == int'(v)) r.tenths = 12'((lo - ZeroIndex) * 10);
			else if (b == int'(v)) r.tenths = 12'((hi - ZeroIndex) * 10);
			else if (b <= a) r.tenths = 12'((lo - ZeroIndex) * 10);
			else begin
				d = (int'(v) >= a) ? (int'(v) - a) : 0;
				r.tenths = 12'((lo - ZeroIndex) * 10 + ((d * 100 + 5) / 10) / (b - a));
			end
		end
		return r;
	endfunction

	// receiver stalls, pattern switches between steady and choppy
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_mode <= 1'b0;
		end else begin
			if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
			out_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 9) != 0);
		end
	end

	// result checker and cycle limit
	always @(posedge clk) begin
		reading_result_t exp_r;
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (pending_temps.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected item: status %0d temp %0d", status, temp_tenths);
			end else begin
				exp_r = pending_temps.pop_front();
				if (status !== exp_r.st || temp_tenths !== exp_r.tenths) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: exp status %0d temp %0d, got status %0d temp %0d",
							exp_r.st, exp_r.tenths, status, temp_tenths);
				end
			end
		end
	end

	// send one reading, expectation queued on acceptance
	// valid stays up; the next item, a gap or a drain follows at this falling edge
	task automatic send_reading(logic [15:0] v);
		in_valid  <= 1'b1;
		adc_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_temps.push_back(predict_temp(v));
		readings_sent++;
		@(negedge clk);
	endtask

	// random gap between bursts
	task automatic idle_gap();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	// wait for every expected result plus pipeline drain
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_temps.size() != 0) @(negedge clk);
		repeat (LatencyCycles + 4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SHORT) short_lvl = val;
		else open_lvl = val;
		@(negedge clk);
	endtask

	// bursts of readings drawn from a fixed mix; the caller chooses the count
	task automatic random_readings(int count);
		int left, burst, sel;
		logic [15:0] v;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 20);
			for (int i = 0; i < burst && left > 0; i++, left--) begin
				sel = $urandom_range(0, 9);
				if (sel < 5) v = 16'($urandom_range(180, 3714));
				else if (sel < 7) v = 16'(cal_table[$urandom_range(0, TableDepth-1)]);
				else if (sel < 8) v = 16'($urandom_range(0, 200));
				else if (sel < 9) v = 16'($urandom_range(3700, 4200));
				else v = 16'($urandom());
				send_reading(v);
			end
			if ($urandom_range(0, 3) != 0) idle_gap();
		end
	endtask

	// directed edges: extremes, every status, exact entries, interpolation
	task automatic test_directed();
		logic [15:0] pts [] = '{16'd0, 16'd15, 16'd16, 16'd179, 16'd180, 16'd181,
			16'd298, 16'd299, 16'd1182, 16'd1200, 16'd1259, 16'd3713, 16'd3714,
			16'd3715, 16'd4095, 16'd4096, 16'd4097, 16'hFFFF, 16'h5555, 16'hAAAA};
		foreach (pts[i]) send_reading(pts[i]);
		drain();
	endtask

	// thresholds overlapping the table, then extremes, then random thresholds
	task automatic test_thresholds();
		write_reg(REG_SHORT, 16'd2000);
		write_reg(REG_OPEN, 16'd3000);
		random_readings(150);
		drain();
		write_reg(REG_SHORT, 16'hFFFF);
		write_reg(REG_OPEN, 16'd0);
		random_readings(50);
		drain();
		write_reg(REG_SHORT, 16'd0);
		write_reg(REG_OPEN, 16'hFFFF);
		send_reading(16'd0);
		send_reading(16'hFFFE);
		send_reading(16'hFFFF);
		random_readings(200);
		drain();
		write_reg(REG_SHORT, 16'($urandom()));
		write_reg(REG_OPEN, 16'($urandom()));
		random_readings(100);
		drain();
	endtask

	// default thresholds, bulk random with gaps
	task automatic test_random();
		write_reg(REG_SHORT, ShortReset);
		write_reg(REG_OPEN, OpenReset);
		random_readings(830);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		adc_value = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_SHORT;
		cfg_wdata = '0;
		short_lvl = ShortReset;
		open_lvl = OpenReset;
		mismatches = 0;
		results_seen = 0;
		readings_sent = 0;
		cycle_count = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random();
		test_thresholds();
		$display("sent %0d readings, checked %0d results over several threshold settings",
			readings_sent, results_seen);
		if (mismatches == 0 && pending_temps.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, pending_temps.size());
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

[ntc_table_temperature.f]
rtl/core/ntc_pkg.sv
rtl/core/ntc_search_step.sv
rtl/core/ntc_interp.sv
rtl/core/ntc_table_temperature.sv
rtl/core/ntc_checker.sv
tb/ntc_table_temperature_tb.sv
